FILE: rtl/core/icsm_pkg.sv
// Shared types and constants for the interval clamp, sort and merge core.
`default_nettype none

package icsm_pkg;

	// Width of a clamped time value in microseconds.
	localparam int DUR_BITS = 39;

	// Largest gap between a merged end and the next start that still merges.
	localparam logic [DUR_BITS:0] MERGE_GAP_US = 40'd1000;

	// Depth of the queue between the front and the back.
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	// Classified segment handed from the front to the back.
	typedef struct packed {
		logic [DUR_BITS-1:0] seg_s;
		logic [DUR_BITS-1:0] seg_e;
		logic                keep;
		logic                last;
	} seg_item_t;

	// One merged result item.
	typedef struct packed {
		logic [DUR_BITS-1:0] res_s;
		logic [DUR_BITS-1:0] res_e;
		logic                last;
		logic                empty;
		logic                ovf;
	} seg_result_t;

	// Back-end sequencer states.
	typedef enum logic [1:0] {
		BK_COLLECT,
		BK_START,
		BK_MERGE
	} bk_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/icsm_if.sv
// Channel interfaces for segment input, merged result output and configuration.
`default_nettype none

interface seg_in_if #(
	parameter int TIME_BITS = 40
);
	logic                        valid;
	logic                        ready;
	logic signed [TIME_BITS-1:0] seg_start;
	logic signed [TIME_BITS-1:0] seg_end;
	logic                        batch_last;

	modport source (output valid, output seg_start, output seg_end, output batch_last,
		input ready);
	modport sink (input valid, input seg_start, input seg_end, input batch_last,
		output ready);
endinterface

interface seg_out_if import icsm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [DUR_BITS-1:0] out_start;
	logic [DUR_BITS-1:0] out_end;
	logic                out_last;
	logic                list_empty;
	logic                overflow;

	modport source (output valid, output out_start, output out_end, output out_last,
		output list_empty, output overflow, input ready);
	modport sink (input valid, input out_start, input out_end, input out_last,
		input list_empty, input overflow, output ready);
endinterface

interface cfg_wr_if import icsm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [DUR_BITS-1:0] clip_duration;

	modport source (output valid, output clip_duration, input ready);
	modport sink (input valid, input clip_duration, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/icsm_front.sv
// Front end: clamps incoming segments and classifies them for the back end.
`default_nettype none

module icsm_front import icsm_pkg::*; #(
	parameter int TIME_BITS = 40
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic signed [TIME_BITS-1:0] in_start,
	input  wire logic signed [TIME_BITS-1:0] in_end,
	input  wire logic                        in_last,
	input  wire logic [DUR_BITS-1:0]         clip_duration,
	output logic                             push_valid,
	output seg_item_t                        push_item,
	input  wire logic                        push_ready
);

	// Compare width wide enough for both the signed time and the duration.
	localparam int CW = (TIME_BITS > DUR_BITS + 1) ? TIME_BITS : DUR_BITS + 1;

	logic                valid_s1;
	logic [DUR_BITS-1:0] start_s1;
	logic [DUR_BITS-1:0] end_s1;
	logic                last_s1;
	logic [DUR_BITS-1:0] start_c;
	logic [DUR_BITS-1:0] end_c;
	logic                keep;
	logic                advance;

	// Clamp a signed time into the range from zero to the duration.
	function automatic logic [DUR_BITS-1:0] clamp_time(
		input logic signed [TIME_BITS-1:0] t,
		input logic [DUR_BITS-1:0]         dur
	);
		logic signed [CW-1:0] tx;
		logic signed [CW-1:0] dx;
		logic [DUR_BITS-1:0]  r;
		tx = CW'(t);
		dx = $signed(CW'(dur));
		if (tx <= $signed(CW'(0))) begin
			r = '0;
		end else if (tx > dx) begin
			r = dur;
		end else begin
			r = tx[DUR_BITS-1:0];
		end
		return r;
	endfunction

	assign start_c = clamp_time(in_start, clip_duration);
	assign end_c   = clamp_time(in_end, clip_duration);

	// A segment survives only if its clamped end lies after its clamped start.
	assign keep = end_s1 > start_s1;

	// Only items that insert a segment or close a batch go to the back end.
	assign push_valid = valid_s1 && (keep || last_s1);
	assign push_item  = '{seg_s: start_s1, seg_e: end_s1, keep: keep, last: last_s1};
	assign advance    = !valid_s1 || !(keep || last_s1) || push_ready;
	assign in_ready   = advance;

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			start_s1 <= start_c;
			end_s1   <= end_c;
			last_s1  <= in_last;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/icsm_queue.sv
// Short queue that decouples the front end from the back end.
`default_nettype none

module icsm_queue import icsm_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       wr_valid,
	output logic            wr_ready,
	input  wire seg_item_t  wr_item,
	output logic            rd_valid,
	input  wire logic       rd_pop,
	output seg_item_t       rd_item
);

	seg_item_t            slots_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_PTR_W:0]     fill_q;
	logic                 do_wr;
	logic                 do_rd;

	assign wr_ready = fill_q != (Q_PTR_W + 1)'(Q_DEPTH);
	assign rd_valid = fill_q != '0;
	assign rd_item  = slots_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_pop && rd_valid;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// Slot storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/icsm_back.sv
// Back end: sorted insertion into a row of cells and the merge pass at batch end.
`default_nettype none

module icsm_back import icsm_pkg::*; #(
	parameter int MAX_SEGMENTS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_valid,
	output logic            q_pop,
	input  wire seg_item_t  q_item,
	output logic            res_valid,
	output seg_result_t     res,
	input  wire logic       res_ready
);

	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

	logic [DUR_BITS-1:0] cell_s_q [MAX_SEGMENTS];
	logic [DUR_BITS-1:0] cell_e_q [MAX_SEGMENTS];
	logic [MAX_SEGMENTS-1:0] gt;

	bk_state_t           state_q, state_d;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    rem_q;
	logic                dropped_q;
	logic [DUR_BITS-1:0] cur_s_q;
	logic [DUR_BITS-1:0] cur_e_q;
	logic                res_valid_q;
	seg_result_t         res_q;

	logic                out_free;
	logic                full;
	logic                mergeable;
	logic                do_insert;
	logic                do_drop;
	logic                do_load;
	logic                do_shift;
	logic                do_extend;
	logic                emit;
	logic                finish;
	seg_result_t         emit_res;

	assign out_free  = !res_valid_q || res_ready;
	assign full      = count_q == CNT_W'(MAX_SEGMENTS);
	assign mergeable = {1'b0, cell_s_q[0]} <= ({1'b0, cur_e_q} + MERGE_GAP_US);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Cells holding a start greater than the new one move up by one place.
	always_comb begin
		for (int i = 0; i < MAX_SEGMENTS; i++) begin
			gt[i] = (CNT_W'(i) < count_q) && (cell_s_q[i] > q_item.seg_s);
		end
	end

	// Sequencer: collect, then walk the sorted cells and emit merged runs.
	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		do_insert = 1'b0;
		do_drop   = 1'b0;
		do_load   = 1'b0;
		do_shift  = 1'b0;
		do_extend = 1'b0;
		emit      = 1'b0;
		finish    = 1'b0;
		emit_res  = '{res_s: cur_s_q, res_e: cur_e_q, last: 1'b0, empty: 1'b0,
			ovf: dropped_q};
		unique case (state_q)
			BK_COLLECT: begin
				q_pop = q_valid;
				if (q_valid) begin
					do_insert = q_item.keep && !full;
					do_drop   = q_item.keep && full;
					if (q_item.last) begin
						state_d = BK_START;
					end
				end
			end
			BK_START: begin
				if (count_q == '0) begin
					emit_res = '{res_s: '0, res_e: '0, last: 1'b1, empty: 1'b1,
						ovf: dropped_q};
					if (out_free) begin
						emit   = 1'b1;
						finish = 1'b1;
					end
				end else begin
					do_load = 1'b1;
					state_d = BK_MERGE;
				end
			end
			BK_MERGE: begin
				if (rem_q == '0) begin
					emit_res.last = 1'b1;
					if (out_free) begin
						emit   = 1'b1;
						finish = 1'b1;
					end
				end else if (mergeable) begin
					do_shift  = 1'b1;
					do_extend = 1'b1;
				end else if (out_free) begin
					emit    = 1'b1;
					do_load = 1'b1;
				end
			end
			default: begin
				state_d = BK_COLLECT;
			end
		endcase
		if (finish) begin
			state_d = BK_COLLECT;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_COLLECT;
			count_q     <= '0;
			rem_q       <= '0;
			dropped_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (finish) begin
				count_q   <= '0;
				dropped_q <= 1'b0;
			end else begin
				if (do_insert) begin
					count_q <= count_q + 1'b1;
				end
				if (do_drop) begin
					dropped_q <= 1'b1;
				end
			end
			if (do_load && state_q == BK_START) begin
				rem_q <= count_q - 1'b1;
			end else if (do_load || do_shift) begin
				rem_q <= rem_q - 1'b1;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Current merged run and the output register.
	always_ff @(posedge clk) begin
		if (do_load) begin
			cur_s_q <= cell_s_q[0];
			cur_e_q <= cell_e_q[0];
		end else if (do_extend && (cell_e_q[0] > cur_e_q)) begin
			cur_e_q <= cell_e_q[0];
		end
		if (emit) begin
			res_q <= emit_res;
		end
	end

	// Row of cells: parallel insert, or shift toward cell zero during the merge.
	for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
		localparam int PREV = (i == 0) ? 0 : i - 1;
		localparam int NEXT = (i == MAX_SEGMENTS - 1) ? i : i + 1;
		logic take_prev;
		logic take_new;
		logic in_range;

		assign in_range  = CNT_W'(i) <= count_q;
		assign take_prev = (i != 0) && gt[PREV];
		assign take_new  = !take_prev && (gt[i] || (CNT_W'(i) == count_q));

		always_ff @(posedge clk) begin
			if (do_insert && in_range) begin
				if (take_prev) begin
					cell_s_q[i] <= cell_s_q[PREV];
					cell_e_q[i] <= cell_e_q[PREV];
				end else if (take_new) begin
					cell_s_q[i] <= q_item.seg_s;
					cell_e_q[i] <= q_item.seg_e;
				end
			end else if (do_load || do_shift) begin
				cell_s_q[i] <= cell_s_q[NEXT];
				cell_e_q[i] <= cell_e_q[NEXT];
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/interval_clamp_sort_merge_core.sv
// Top level of the interval clamp, sort and merge core.
//
// Usage: segments arrive on in_ch, one transaction per segment, with
// batch_last on the final segment of a batch. Each start and end is clamped
// into the range from zero to clip_duration, empty segments are dropped and
// the rest are inserted in start order into a row of MAX_SEGMENTS cells.
// After the last segment the cells are walked once and the merged list goes
// out on out_ch, out_last marking its final transaction; a batch with no
// surviving segment yields one transaction with list_empty set.
// Throughput: one segment per cycle while a batch is collected and the queue
// has room; the insert step of the back end compares all cells at once. The
// merge pass walks the stored segments by the one-per-cycle shift of the cells
// toward cell zero, which can wait while a stalled receiver holds a result. An
// input segment passes the front-end stage register and the queue before its
// insertion; after the last segment the first result is loaded into the output
// register in the start or merge state of the back end. cfg_ch writes
// clip_duration and is always ready; write it only while no batch is in
// flight. Reset clears the count, the dropped flag and clip_duration. A stalled
// receiver holds the result and, through the queue, eventually stops input.
`default_nettype none

module interval_clamp_sort_merge_core import icsm_pkg::*; #(
	parameter int MAX_SEGMENTS = 32,
	parameter int TIME_BITS    = 40
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	seg_in_if.sink     in_ch,
	seg_out_if.source  out_ch,
	cfg_wr_if.sink     cfg_ch
);

	logic [DUR_BITS-1:0]         clip_duration_q;
	logic signed [TIME_BITS-1:0] in_start;
	logic signed [TIME_BITS-1:0] in_end;
	logic                        push_valid;
	logic                        push_ready;
	seg_item_t                   push_item;
	logic                        q_valid;
	logic                        q_pop;
	seg_item_t                   q_item;
	seg_result_t                 res;

	assign in_start = in_ch.seg_start;
	assign in_end   = in_ch.seg_end;

	// Configuration register.
	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_duration_q <= '0;
		end else if (cfg_ch.valid) begin
			clip_duration_q <= cfg_ch.clip_duration;
		end
	end

	// Front end: clamp and classify.
	icsm_front #(
		.TIME_BITS(TIME_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_ch.valid),
		.in_ready     (in_ch.ready),
		.in_start     (in_start),
		.in_end       (in_end),
		.in_last      (in_ch.batch_last),
		.clip_duration(clip_duration_q),
		.push_valid   (push_valid),
		.push_item    (push_item),
		.push_ready   (push_ready)
	);

	// Decoupling queue.
	icsm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(push_valid),
		.wr_ready(push_ready),
		.wr_item (push_item),
		.rd_valid(q_valid),
		.rd_pop  (q_pop),
		.rd_item (q_item)
	);

	// Back end: sorted table and merge pass.
	icsm_back #(
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item),
		.res_valid(out_ch.valid),
		.res      (res),
		.res_ready(out_ch.ready)
	);

	assign out_ch.out_start  = res.res_s;
	assign out_ch.out_end    = res.res_e;
	assign out_ch.out_last   = res.last;
	assign out_ch.list_empty = res.empty;
	assign out_ch.overflow   = res.ovf;

endmodule

`default_nettype wire

FILE: rtl/core/icsm_checker.sv
// Port-level checker for the result channel, bound to the top level.
`default_nettype none

module icsm_checker import icsm_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [DUR_BITS-1:0] out_start,
	input wire logic [DUR_BITS-1:0] out_end,
	input wire logic                out_last,
	input wire logic                list_empty,
	input wire logic                overflow
);

	logic                in_batch_q;
	logic [DUR_BITS:0]   prev_end_q;

	// Track the end of the last accepted result while its batch is still open.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_batch_q <= 1'b0;
			prev_end_q <= '0;
		end else if (out_valid && out_ready) begin
			in_batch_q <= !out_last;
			prev_end_q <= {1'b0, out_end};
		end
	end

	// A stalled result transaction stays offered.
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	// The empty marker is the only and therefore the final transaction.
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && list_empty |-> out_last && out_start == '0 && out_end == '0)
		else $error("empty result not final or not zeroed");

	// Every merged segment is nonempty.
	a_end_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !list_empty |-> out_end > out_start)
		else $error("merged segment end not after start");

	// Within a batch, the next merged segment starts beyond the previous end and the gap.
	a_sorted_runs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_batch_q |-> {1'b0, out_start} > prev_end_q + MERGE_GAP_US)
		else $error("merged segments out of order or too close");

	// Overflow is constant across the transactions of one batch.
	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last ##1 out_valid |-> overflow == $past(overflow))
		else $error("overflow changed within a batch");

endmodule

bind interval_clamp_sort_merge_core icsm_checker u_icsm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_start (out_ch.out_start),
	.out_end   (out_ch.out_end),
	.out_last  (out_ch.out_last),
	.list_empty(out_ch.list_empty),
	.overflow  (out_ch.overflow)
);

`default_nettype wire

FILE: tb/interval_merge_checker.sv
// Checker that predicts the merged segment lists and compares them with the core's results.
module interval_merge_checker import icsm_pkg::*; #(
	parameter int MAX_SEGMENTS = 32,
	parameter int TIME_BITS    = 40
) (
	input  logic clk,
	input  logic arst_n,
	seg_in_if    in_mon,
	seg_out_if   out_mon,
	cfg_wr_if    cfg_mon,
	output int   mismatches,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	// Predicted state: clamp ceiling, start-ordered table, fill level and drop flag.
	bit [DUR_BITS-1:0] clip_us;
	bit [DUR_BITS-1:0] tab_s [MAX_SEGMENTS];
	bit [DUR_BITS-1:0] tab_e [MAX_SEGMENTS];
	int                stored;
	bit                dropped;
	seg_result_t       merged_q [$];

	// Print one line per mismatch and count it.
	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	// Clamp a signed time into the range from zero to the configured duration.
	function automatic bit [DUR_BITS-1:0] clamp_us(input logic signed [TIME_BITS-1:0] t);
		longint v;
		v = t;
		if (v <= 0)
			return '0;
		if (v > longint'({1'b0, clip_us}))
			return clip_us;
		return v[DUR_BITS-1:0];
	endfunction

	// Insert a surviving segment after every entry whose start is not larger.
	task automatic file_segment(input bit [DUR_BITS-1:0] s, input bit [DUR_BITS-1:0] e);
		int pos;
		if (stored >= MAX_SEGMENTS) begin
			dropped = 1'b1;
			return;
		end
		pos = stored;
		while (pos > 0 && tab_s[pos-1] > s) begin
			tab_s[pos] = tab_s[pos-1];
			tab_e[pos] = tab_e[pos-1];
			pos--;
		end
		tab_s[pos] = s;
		tab_e[pos] = e;
		stored++;
	endtask

	function automatic seg_result_t make_result(input bit [DUR_BITS-1:0] s,
			input bit [DUR_BITS-1:0] e, input bit last, input bit empty, input bit ovf);
		seg_result_t r;
		r.res_s = s;
		r.res_e = e;
		r.last  = last;
		r.empty = empty;
		r.ovf   = ovf;
		return r;
	endfunction

	// Append one predicted result at the tail of the queue.
	task automatic queue_result(input seg_result_t r);
		merged_q = {merged_q, r};
	endtask

	// Walk the table in start order, merging close segments, and queue the results.
	task automatic emit_merged();
		bit [DUR_BITS-1:0] run_s;
		bit [DUR_BITS-1:0] run_e;
		if (stored == 0) begin
			queue_result(make_result('0, '0, 1'b1, 1'b1, dropped));
		end else begin
			run_s = tab_s[0];
			run_e = tab_e[0];
			for (int i = 1; i < stored; i++) begin
				if ({1'b0, tab_s[i]} <= {1'b0, run_e} + MERGE_GAP_US) begin
					if (tab_e[i] > run_e)
						run_e = tab_e[i];
				end else begin
					queue_result(make_result(run_s, run_e, 1'b0, 1'b0, dropped));
					run_s = tab_s[i];
					run_e = tab_e[i];
				end
			end
			queue_result(make_result(run_s, run_e, 1'b1, 1'b0, dropped));
		end
		stored  = 0;
		dropped = 1'b0;
	endtask

	// Follow every transaction on the three channels.
	always @(posedge clk or negedge arst_n) begin
		seg_result_t       want;
		bit [DUR_BITS-1:0] s;
		bit [DUR_BITS-1:0] e;
		if (!arst_n) begin
			clip_us    = '0;
			stored     = 0;
			dropped    = 1'b0;
			mismatches = 0;
			merged_q.delete();
			outstanding <= 0;
		end else begin
			if (cfg_mon.valid && cfg_mon.ready)
				clip_us = cfg_mon.clip_duration;

			if (in_mon.valid && in_mon.ready) begin
				s = clamp_us(in_mon.seg_start);
				e = clamp_us(in_mon.seg_end);
				if (e > s)
					file_segment(s, e);
				if (in_mon.batch_last)
					emit_merged();
			end

			if (out_mon.valid && out_mon.ready) begin
				if (merged_q.size() == 0) begin
					report_mismatch("result transaction with no result expected");
				end else begin
					want = merged_q.pop_front();
					if (out_mon.out_start !== want.res_s)
						report_mismatch($sformatf("out_start got %0d want %0d",
							out_mon.out_start, want.res_s));
					if (out_mon.out_end !== want.res_e)
						report_mismatch($sformatf("out_end got %0d want %0d",
							out_mon.out_end, want.res_e));
					if (out_mon.out_last !== want.last)
						report_mismatch($sformatf("out_last got %b want %b",
							out_mon.out_last, want.last));
					if (out_mon.list_empty !== want.empty)
						report_mismatch($sformatf("list_empty got %b want %b",
							out_mon.list_empty, want.empty));
					if (out_mon.overflow !== want.ovf)
						report_mismatch($sformatf("overflow got %b want %b",
							out_mon.overflow, want.ovf));
				end
			end

			outstanding <= merged_q.size();
		end
	end

endmodule

FILE: tb/interval_clamp_sort_merge_core_tb.sv
// Top of the testbench: clock, reset, segment and configuration stimulus, and the verdict.
module interval_clamp_sort_merge_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import icsm_pkg::*;

	localparam int MAX_SEGS      = 32;
	localparam int TBITS         = 40;
	localparam int IDLE_LIMIT    = 4000;
	localparam int SETTLE_CYCLES = 48;
	localparam longint unsigned DUR_MAX = (64'd1 << DUR_BITS) - 1;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	bit   calm;
	longint unsigned clip_now;
	int   ready_hold = 0;
	int   idle_cycles = 0;

	seg_in_if #(.TIME_BITS(TBITS)) in_ch ();
	seg_out_if                     out_ch ();
	cfg_wr_if                      cfg_ch ();

	interval_clamp_sort_merge_core #(
		.MAX_SEGMENTS(MAX_SEGS),
		.TIME_BITS   (TBITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	interval_merge_checker #(
		.MAX_SEGMENTS(MAX_SEGS),
		.TIME_BITS   (TBITS)
	) merge_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_mon     (in_ch),
		.out_mon    (out_ch),
		.cfg_mon    (cfg_ch),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	// 12 ns clock.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Idle length: mostly none, often short, now and then long.
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic longint unsigned rand_below(input longint unsigned n);
		longint unsigned r;
		r = {$urandom, $urandom};
		return r % n;
	endfunction

	function automatic logic [TBITS-1:0] extreme_time();
		case ($urandom_range(0, 6))
			0: return {1'b1, {(TBITS-1){1'b0}}};
			1: return {1'b0, {(TBITS-1){1'b1}}};
			2: return '1;
			3: return '0;
			4: return TBITS'(1);
			5: return clip_now[TBITS-1:0];
			default: return TBITS'(clip_now + 1);
		endcase
	endfunction

	// Receiver side: ready held high or low for runs of random length.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			ready_hold   <= 0;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if (calm) begin
			out_ch.ready <= 1'b1;
		end else begin
			out_ch.ready <= ($urandom_range(0, 99) < 65);
			ready_hold <= pick_gap();
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offer one segment after a random gap and wait for its transaction.
	task automatic push_segment(input logic [TBITS-1:0] s, input logic [TBITS-1:0] e,
			input bit last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.seg_start  <= s;
		in_ch.seg_end    <= e;
		in_ch.batch_last <= last;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// Stop offering, wait for every expected result, then let the core settle.
	task automatic close_phase();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_clip(input longint unsigned value);
		clip_now = value;
		cfg_ch.valid         <= 1'b1;
		cfg_ch.clip_duration <= value[DUR_BITS-1:0];
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// One batch: segments clustered in a window so that they overlap and merge,
	// mixed with reversed, raw and extreme segments.
	task automatic push_batch(input int n);
		longint unsigned span;
		longint unsigned base;
		longint          s_val;
		longint          e_val;
		logic [63:0]     raw;
		logic [TBITS-1:0] s_bits;
		logic [TBITS-1:0] e_bits;
		int              noise_pct;
		int              pick;
		noise_pct = (n > MAX_SEGS) ? 5 : 25;
		case ($urandom_range(0, 2))
			0: span = 4000;
			1: span = 60000;
			default: span = 64'd1 << 22;
		endcase
		if (span > clip_now)
			span = clip_now + 1;
		base = rand_below(clip_now + 1);
		for (int k = 0; k < n; k++) begin
			pick  = $urandom_range(0, 99);
			s_val = base + rand_below(span);
			e_val = s_val + 1 + rand_below(span / 8 + 1);
			if (pick >= noise_pct) begin
				s_bits = s_val[TBITS-1:0];
				e_bits = e_val[TBITS-1:0];
			end else if (pick < noise_pct / 3) begin
				s_bits = e_val[TBITS-1:0];
				e_bits = s_val[TBITS-1:0];
			end else if (pick < 2 * noise_pct / 3) begin
				raw    = {$urandom, $urandom};
				s_bits = raw[TBITS-1:0];
				raw    = {$urandom, $urandom};
				e_bits = raw[TBITS-1:0];
			end else begin
				s_bits = extreme_time();
				e_bits = pick[0] ? extreme_time() : e_val[TBITS-1:0];
			end
			push_segment(s_bits, e_bits, k == n - 1);
		end
	endtask

	function automatic int pick_batch_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 6);
		if (r < 90)
			return $urandom_range(7, 20);
		return $urandom_range(MAX_SEGS + 1, MAX_SEGS + 8);
	endfunction

	// Configure a duration, then stream random batches until the item quota is met.
	task automatic run_phase(input longint unsigned clip, input int quota, input int lead_len);
		int sent;
		int n;
		set_clip(clip);
		sent = 0;
		while (sent < quota) begin
			calm = ($urandom_range(0, 4) == 0);
			n = (sent == 0 && lead_len > 0) ? lead_len : pick_batch_len();
			push_batch(n);
			sent += n;
		end
		calm = 1'b0;
		close_phase();
	endtask

	initial begin
		calm     = 1'b0;
		clip_now = 0;
		arst_n               <= 1'b0;
		in_ch.valid          <= 1'b0;
		in_ch.seg_start      <= '0;
		in_ch.seg_end        <= '0;
		in_ch.batch_last     <= 1'b0;
		cfg_ch.valid         <= 1'b0;
		cfg_ch.clip_duration <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Duration is zero out of reset, so every segment collapses and the list is empty.
		push_segment(40'sd5, 40'sd10, 1'b1);
		close_phase();

		set_clip(100000);
		// Full-range segment clamps to the whole duration.
		push_segment({1'b1, {(TBITS-1){1'b0}}}, {1'b0, {(TBITS-1){1'b1}}}, 1'b1);
		// Out-of-order inserts, a gap of exactly the merge distance, one just past it,
		// equal starts, zero-length, reversed, beyond-duration and negative segments.
		push_segment(40'sd5000, 40'sd6000, 1'b0);
		push_segment(40'sd1000, 40'sd2000, 1'b0);
		push_segment(40'sd3000, 40'sd4500, 1'b0);
		push_segment(40'sd7001, 40'sd8000, 1'b0);
		push_segment(40'sd7001, 40'sd7500, 1'b0);
		push_segment(40'sd8000, 40'sd8000, 1'b0);
		push_segment(40'sd9000, 40'sd8500, 1'b0);
		push_segment(40'sd200000, 40'sd300000, 1'b0);
		push_segment(-40'sd5, 40'sd500, 1'b1);
		// Batch whose only segment is reversed: empty list.
		push_segment(40'sd9000, 40'sd8500, 1'b1);
		// Negative segment dropped, equal starts, and a merge at exactly the gap.
		push_segment(-40'sd100, -40'sd5, 1'b0);
		push_segment(40'sd50, 40'sd60, 1'b0);
		push_segment(40'sd50, 40'sd70, 1'b0);
		push_segment(40'sd1070, 40'sd1080, 1'b1);
		close_phase();

		// Random phases over the largest, a small, zero and an arbitrary duration.
		run_phase(DUR_MAX, 60, MAX_SEGS + 4);
		run_phase($urandom_range(1, 6000), 40, 0);
		run_phase(0, 15, 0);
		run_phase(rand_below(DUR_MAX + 1), 60, 0);

		if (mismatches == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/icsm_pkg.sv
rtl/core/icsm_if.sv
rtl/core/icsm_front.sv
rtl/core/icsm_queue.sv
rtl/core/icsm_back.sv
rtl/core/interval_clamp_sort_merge_core.sv
rtl/core/icsm_checker.sv
tb/interval_merge_checker.sv
tb/interval_clamp_sort_merge_core_tb.sv
